// File: design/qmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmt_pkg: shared types and constants of the quote microprice tracker
// Command word between front and back, register map, sequencer states.
// ----------------------------------------------------------------------------
package qmt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int MID_W         = 48;
   localparam int PRICE_W       = 32;
   localparam int SIZE_W        = 32;
   localparam int DIV_W         = SIZE_W + 1;
   localparam int SPREAD_W      = 16;
   localparam int THR_W         = 32;
   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 4;

   typedef enum logic [1:0] {
      CMD_EOD,
      CMD_INVALID,
      CMD_MIDPOINT,
      CMD_FRACTION
   } cmd_kind_type;

   typedef enum logic [1:0] {
      CSR_MAX_SPREAD    = 2'd0,
      CSR_CHECK_OUT     = 2'd1,
      CSR_OUT_THRESHOLD = 2'd2,
      CSR_HALVE_MID     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MID,
      ST_SATURATE,
      ST_FLAGS,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic                spread_wide;
      logic [PRICE_W-1:0]  bid;
      logic [PRICE_W-1:0]  ask;
      logic [SIZE_W-1:0]   bid_size;
      logic [DIV_W-1:0]    divisor;
   } cmd_type;

   typedef struct packed {
      logic [SPREAD_W-1:0] max_spread;
      logic                check_trading_out;
      logic [THR_W-1:0]    out_threshold;
      logic                halve_mid;
   } csr_type;

   typedef struct packed {
      logic              price_valid;
      logic [MID_W-1:0]  weighted_mid;
      logic              bid_trading_out;
      logic              ask_trading_out;
   } result_type;

endpackage

// File: design/qmt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmt_front: quote intake and classification
// Checks sizes and spread, picks the command kind, forms the divisor.
// ----------------------------------------------------------------------------
module qmt_front
   import qmt_pkg::*;
(
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_op,
   input  logic [SIZE_W-1:0]         req_bid_size,
   input  logic signed [PRICE_W-1:0] req_best_bid,
   input  logic signed [PRICE_W-1:0] req_best_ask,
   input  logic [SIZE_W-1:0]         req_ask_size,
   input  logic [SPREAD_W-1:0]       max_spread,
   input  logic                      queue_full,
   output logic                      push,
   output cmd_type                   push_cmd
);

   logic [PRICE_W:0] spread;
   logic             spread_pos;
   logic             spread_wide;
   logic             quote_ok;

   always_comb begin
      spread      = {req_best_ask[PRICE_W-1], req_best_ask} -
                    {req_best_bid[PRICE_W-1], req_best_bid};
      spread_pos  = !spread[PRICE_W] && (spread != '0);
      spread_wide = spread_pos && (spread[PRICE_W-1:0] > PRICE_W'(1));
      quote_ok    = (req_bid_size != '0) && (req_ask_size != '0) && spread_pos &&
                    (spread[PRICE_W-1:0] <= PRICE_W'(max_spread));

      push_cmd.spread_wide = spread_wide;
      push_cmd.bid         = req_best_bid;
      push_cmd.ask         = req_best_ask;
      push_cmd.bid_size    = req_bid_size;
      push_cmd.divisor     = {1'b0, req_bid_size} + {1'b0, req_ask_size};
      if (req_op) begin
         push_cmd.kind = CMD_EOD;
      end else if (!quote_ok) begin
         push_cmd.kind = CMD_INVALID;
      end else if (spread_wide) begin
         push_cmd.kind = CMD_MIDPOINT;
      end else begin
         push_cmd.kind = CMD_FRACTION;
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

// File: design/qmt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmt_queue: command queue between front and back
// Small circular buffer of command words.
// ----------------------------------------------------------------------------
module qmt_queue
   import qmt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: design/qmt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmt_back: mid computation sequencer
// Radix-2 size-ratio divider, mid build, halving and saturation,
// trading-out compares, and the result register.
// ----------------------------------------------------------------------------
module qmt_back
   import qmt_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head_cmd,
   input  logic       queue_empty,
   output logic       pop,
   input  csr_type    csr,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_word
);

   // working width: holds bid shifted by FRAC_BITS, the held mid, and their difference
   localparam int BASE_W = ((PRICE_W + 2 + FRAC_BITS) > MID_W) ?
                           (PRICE_W + 2 + FRAC_BITS) : MID_W;
   localparam int WW     = BASE_W + 1;
   localparam int CNT_W  = $clog2(FRAC_BITS + 1);
   localparam int TOP_W  = WW - MID_W + 1;

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [DIV_W-1:0]      rem_ff, rem_in;
   logic [FRAC_BITS-1:0]  quot_ff, quot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [WW-1:0]  mid_ff, mid_in;
   logic [MID_W-1:0]      held_ff, held_in;
   logic                  valid_ff, valid_in;
   logic                  bid_out_ff, bid_out_in;
   logic                  ask_out_ff, ask_out_in;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_ff, out_in;

   logic                  load_out;
   logic [DIV_W:0]        shifted;
   logic [PRICE_W:0]      price_sum;
   logic signed [WW-1:0]  half;
   logic [TOP_W-1:0]      half_top;
   logic signed [WW-1:0]  held_w;
   logic signed [WW-1:0]  bid_w;
   logic signed [WW-1:0]  ask_w;
   logic signed [WW-1:0]  thr_w;

   assign load_out  = (state_ff == ST_DONE) && (!out_valid_ff || rsp_ready);
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               unique case (head_cmd.kind)
                  CMD_EOD:      state_in = ST_DONE;
                  CMD_INVALID:  state_in = ST_FLAGS;
                  CMD_MIDPOINT: state_in = ST_MID;
                  CMD_FRACTION: state_in = ST_DIVIDE;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_MID;
            end
         end
         ST_MID:      state_in = ST_SATURATE;
         ST_SATURATE: state_in = ST_FLAGS;
         ST_FLAGS:    state_in = ST_DONE;
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop        = 1'b0;
      cmd_in     = cmd_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      cnt_in     = cnt_ff;
      mid_in     = mid_ff;
      held_in    = held_ff;
      valid_in   = valid_ff;
      bid_out_in = bid_out_ff;
      ask_out_in = ask_out_ff;
      out_in     = out_ff;

      shifted   = {rem_ff, 1'b0};
      price_sum = {cmd_ff.ask[PRICE_W-1], cmd_ff.ask} + {cmd_ff.bid[PRICE_W-1], cmd_ff.bid};
      half      = csr.halve_mid ? (mid_ff >>> 1) : mid_ff;
      half_top  = half[WW-1:MID_W-1];
      held_w    = WW'($signed(held_ff));
      bid_w     = WW'($signed(cmd_ff.bid)) <<< FRAC_BITS;
      ask_w     = WW'($signed(cmd_ff.ask)) <<< FRAC_BITS;
      thr_w     = $signed(WW'(csr.out_threshold));

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop     = 1'b1;
               cmd_in  = head_cmd;
               rem_in  = {1'b0, head_cmd.bid_size};
               quot_in = '0;
               cnt_in  = CNT_W'(FRAC_BITS);
               case (head_cmd.kind)
                  CMD_EOD: begin
                     held_in  = '0;
                     valid_in = 1'b0;
                  end
                  CMD_INVALID: valid_in = 1'b0;
                  default: ;
               endcase
            end
         end
         ST_DIVIDE: begin
            // one quotient bit per cycle, remainder stays below the divisor
            if (shifted >= {1'b0, cmd_ff.divisor}) begin
               rem_in  = DIV_W'(shifted - {1'b0, cmd_ff.divisor});
               quot_in = {quot_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               rem_in  = shifted[DIV_W-1:0];
               quot_in = {quot_ff[FRAC_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end
         ST_MID: begin
            if (cmd_ff.kind == CMD_MIDPOINT) begin
               mid_in = WW'($signed(price_sum)) <<< (FRAC_BITS - 1);
            end else begin
               // low bits of the shifted bid are zero, so or-in the fraction
               mid_in = bid_w | $signed(WW'(quot_ff));
            end
         end
         ST_SATURATE: begin
            valid_in = 1'b1;
            if ((half_top == '0) || (half_top == '1)) begin
               held_in = half[MID_W-1:0];
            end else if (half[WW-1]) begin
               held_in = {1'b1, {(MID_W-1){1'b0}}};
            end else begin
               held_in = {1'b0, {(MID_W-1){1'b1}}};
            end
         end
         ST_FLAGS: begin
            if (csr.check_trading_out) begin
               if (cmd_ff.spread_wide) begin
                  bid_out_in = 1'b0;
                  ask_out_in = 1'b0;
               end else begin
                  bid_out_in = (held_w - bid_w) < thr_w;
                  ask_out_in = (ask_w - held_w) < thr_w;
               end
            end
         end
         ST_DONE: begin
            if (load_out) begin
               out_in.price_valid     = valid_ff;
               out_in.weighted_mid    = held_ff;
               out_in.bid_trading_out = bid_out_ff;
               out_in.ask_trading_out = ask_out_ff;
            end
         end
         default: ;
      endcase

      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         valid_ff     <= 1'b0;
         bid_out_ff   <= 1'b0;
         ask_out_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         valid_ff     <= valid_in;
         bid_out_ff   <= bid_out_in;
         ask_out_ff   <= ask_out_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      mid_ff  <= mid_in;
      out_ff  <= out_in;
   end

endmodule

// File: design/quote_microprice_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quote_microprice_tracker_unit: top-of-book weighted mid tracker
// Register block, quote intake, command queue and mid sequencer.
//
//   port group   direction  handshake            moves
//   req_*        in         req_valid/req_ready  one quote or end-of-day word
//   rsp_*        out        rsp_valid/rsp_ready  one result word per input word
//   APB          in/out     psel/penable/pready  register writes and reads
//
// A one-tick quote passes through the radix-2 divider, which makes one quotient
// bit per cycle, then the mid, saturate, flags and done states; a wider-spread
// quote skips the divider, an invalid quote goes to flags, end-of-day to done.
// Reset clears the queue, held mid, flags and result valid flag, and loads the
// register defaults. A stalled rsp_ready holds the result word; the queue keeps
// taking input words until it holds two.
// ----------------------------------------------------------------------------
module quote_microprice_tracker_unit
   import qmt_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_op,
   input  logic [SIZE_W-1:0]         req_bid_size,
   input  logic signed [PRICE_W-1:0] req_best_bid,
   input  logic signed [PRICE_W-1:0] req_best_ask,
   input  logic [SIZE_W-1:0]         req_ask_size,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_price_valid,
   output logic signed [MID_W-1:0]   rsp_weighted_mid,
   output logic                      rsp_bid_trading_out,
   output logic                      rsp_ask_trading_out,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   csr_type       csr_ff, csr_in;
   csr_index_type csr_index;
   logic          csr_write;

   logic          push;
   cmd_type       push_cmd;
   logic          pop;
   cmd_type       head_cmd;
   logic          queue_full;
   logic          queue_empty;
   result_type    rsp_word;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[3:2]);

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_SPREAD:    csr_in.max_spread        = pwdata[SPREAD_W-1:0];
            CSR_CHECK_OUT:     csr_in.check_trading_out = pwdata[0];
            CSR_OUT_THRESHOLD: csr_in.out_threshold     = pwdata[THR_W-1:0];
            CSR_HALVE_MID:     csr_in.halve_mid         = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_MAX_SPREAD:    prdata = CSR_DATA_W'(csr_ff.max_spread);
         CSR_CHECK_OUT:     prdata = CSR_DATA_W'(csr_ff.check_trading_out);
         CSR_OUT_THRESHOLD: prdata = CSR_DATA_W'(csr_ff.out_threshold);
         CSR_HALVE_MID:     prdata = CSR_DATA_W'(csr_ff.halve_mid);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.max_spread        <= SPREAD_W'(1);
         csr_ff.check_trading_out <= 1'b0;
         csr_ff.out_threshold     <= '0;
         csr_ff.halve_mid         <= 1'b0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   qmt_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_bid_size (req_bid_size),
      .req_best_bid (req_best_bid),
      .req_best_ask (req_best_ask),
      .req_ask_size (req_ask_size),
      .max_spread   (csr_ff.max_spread),
      .queue_full   (queue_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   qmt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   qmt_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .queue_empty (queue_empty),
      .pop         (pop),
      .csr         (csr_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

   assign rsp_price_valid     = rsp_word.price_valid;
   assign rsp_weighted_mid    = rsp_word.weighted_mid;
   assign rsp_bid_trading_out = rsp_word.bid_trading_out;
   assign rsp_ask_trading_out = rsp_word.ask_trading_out;

endmodule
